// ===== hw/rtl/lcts_pkg.sv =====
// ============================================================================
// lcts_pkg
// Shared types and constants for the lidar/camera timestamp synchronizer.
// ============================================================================
package lcts_pkg;

    localparam int TS_W        = 30;
    localparam int TAG_W       = 16;
    localparam int CAM_FIELD_W = 3;
    localparam int ACTION_W    = 2;

    // Action codes of an input transaction.
    localparam logic [ACTION_W-1:0] ACT_LIDAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CAMERA = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;

    // Kind codes of a result transaction.
    localparam logic KIND_LIDAR  = 1'b0;
    localparam logic KIND_CAMERA = 1'b1;

    // Default match window, 50 ms.
    localparam logic [TS_W-1:0] TOL_RESET = 30'd50000000;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [CAM_FIELD_W-1:0] camera_index;
        logic [TS_W-1:0]        timestamp_ns;
        logic [TAG_W-1:0]       frame_tag;
    } t_in_item;

    typedef struct packed {
        logic                   kind;
        logic [CAM_FIELD_W-1:0] source_camera;
        logic [TAG_W-1:0]       out_tag;
        logic [TS_W-1:0]        out_timestamp;
        logic                   last;
    } t_out_item;

    typedef struct packed {
        logic [TS_W-1:0]  ts;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CAM_RD,
        ST_CAM_CMP,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                   accept;
        logic                   load_lidar;
        logic                   pop_lidar;
        logic                   cam_pop;
        logic                   load_cam;
        logic                   emit;
        logic                   emit_last;
        logic [CAM_FIELD_W-1:0] cam;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lidar_empty;
        logic any_cam_empty;
        logic cam_empty;
        logic cam_match;
    } t_dp_status;

endpackage

// ===== hw/rtl/lcts_datapath.sv =====
// ============================================================================
// lcts_datapath
// Frame FIFOs, tolerance register, match compare and result registers.
// ============================================================================
module lcts_datapath
    import lcts_pkg::*;
#(
    parameter int NUM_CAMERAS = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_in_item        i_item,
    input  logic            i_cfg_we,
    input  logic [TS_W-1:0] i_cfg_wdata,
    input  t_dp_cmd         i_cmd,
    output t_dp_status      o_status,
    output logic            o_strobe,
    output t_out_item       o_result
);

    localparam int IDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W      = IDX_W + 1;
    localparam int CAM_W      = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
    localparam int LMEM_DEPTH = 2 ** IDX_W;
    localparam int CMEM_DEPTH = 2 ** (CAM_W + IDX_W);

    logic [TS_W-1:0]  r_tol;
    logic [TS_W-1:0]  r_lts;
    t_out_item        r_pend;
    t_out_item        r_out;
    logic             r_out_valid;

    t_entry           lidar_mem [LMEM_DEPTH];
    t_entry           r_l_rd;
    logic [IDX_W-1:0] r_l_head;
    logic [CNT_W-1:0] r_l_cnt;

    t_entry           cam_mem [CMEM_DEPTH];
    t_entry           r_c_rd;
    logic [IDX_W-1:0] r_c_head [NUM_CAMERAS];
    logic [CNT_W-1:0] r_c_cnt  [NUM_CAMERAS];

    logic [CAM_W-1:0]       sel;
    logic [IDX_W-1:0]       sel_head;
    logic [CNT_W-1:0]       sel_cnt;
    logic [IDX_W-1:0]       l_tail;
    logic [IDX_W-1:0]       c_tail;
    logic [SUM_W-1:0]       l_sum;
    logic [SUM_W-1:0]       c_sum;
    logic [IDX_W-1:0]       l_head_inc;
    logic [IDX_W-1:0]       c_head_inc;
    logic                   lidar_push;
    logic                   cam_push;
    logic                   cam_ok;
    logic [NUM_CAMERAS-1:0] cam_empty_vec;
    logic [TS_W-1:0]        diff;

    // Arrivals select by the incoming index, the tick walk by the controller's camera.
    assign sel      = i_cmd.accept ? i_item.camera_index[CAM_W-1:0] : i_cmd.cam[CAM_W-1:0];
    assign sel_head = r_c_head[sel];
    assign sel_cnt  = r_c_cnt[sel];

    assign cam_ok     = 4'(i_item.camera_index) < 4'(NUM_CAMERAS);
    assign lidar_push = i_cmd.accept && (i_item.action == ACT_LIDAR)
                        && (r_l_cnt != CNT_W'(QUEUE_DEPTH));
    assign cam_push   = i_cmd.accept && (i_item.action == ACT_CAMERA) && cam_ok
                        && (sel_cnt != CNT_W'(QUEUE_DEPTH));

    // Tail slot is head plus fill level, wrapped once.
    always_comb begin
        l_sum = SUM_W'(r_l_head) + SUM_W'(r_l_cnt);
        if (l_sum >= SUM_W'(QUEUE_DEPTH)) begin
            l_sum = l_sum - SUM_W'(QUEUE_DEPTH);
        end
        l_tail = l_sum[IDX_W-1:0];

        c_sum = SUM_W'(sel_head) + SUM_W'(sel_cnt);
        if (c_sum >= SUM_W'(QUEUE_DEPTH)) begin
            c_sum = c_sum - SUM_W'(QUEUE_DEPTH);
        end
        c_tail = c_sum[IDX_W-1:0];
    end

    assign l_head_inc = (r_l_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_l_head + 1'b1;
    assign c_head_inc = (sel_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : sel_head + 1'b1;

    always_comb begin
        for (int c = 0; c < NUM_CAMERAS; c++) begin
            cam_empty_vec[c] = (r_c_cnt[c] == '0);
        end
    end

    assign diff = (r_c_rd.ts >= r_lts) ? (r_c_rd.ts - r_lts) : (r_lts - r_c_rd.ts);

    assign o_status.lidar_empty   = (r_l_cnt == '0);
    assign o_status.any_cam_empty = |cam_empty_vec;
    assign o_status.cam_empty     = (sel_cnt == '0);
    assign o_status.cam_match     = (diff <= r_tol);

    // Lidar FIFO storage; the head entry is read every cycle.
    always_ff @(posedge i_clk) begin
        if (lidar_push) begin
            lidar_mem[l_tail] <= '{ts: i_item.timestamp_ns, tag: i_item.frame_tag};
        end
        r_l_rd <= lidar_mem[r_l_head];
    end

    // Camera FIFO storage, one region per camera.
    always_ff @(posedge i_clk) begin
        if (cam_push) begin
            cam_mem[{sel, c_tail}] <= '{ts: i_item.timestamp_ns, tag: i_item.frame_tag};
        end
        r_c_rd <= cam_mem[{sel, sel_head}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_head <= '0;
            r_l_cnt  <= '0;
            for (int c = 0; c < NUM_CAMERAS; c++) begin
                r_c_head[c] <= '0;
                r_c_cnt[c]  <= '0;
            end
        end else begin
            if (lidar_push) begin
                r_l_cnt <= r_l_cnt + 1'b1;
            end else if (i_cmd.pop_lidar) begin
                r_l_head <= l_head_inc;
                r_l_cnt  <= r_l_cnt - 1'b1;
            end
            if (cam_push) begin
                r_c_cnt[sel] <= sel_cnt + 1'b1;
            end else if (i_cmd.cam_pop) begin
                r_c_head[sel] <= c_head_inc;
                r_c_cnt[sel]  <= sel_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= TOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            r_out_valid <= i_cmd.emit;
        end
    end

    // The pending result is held back one step so its last flag is known when sent.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= '{kind: r_pend.kind, source_camera: r_pend.source_camera,
                       out_tag: r_pend.out_tag, out_timestamp: r_pend.out_timestamp,
                       last: i_cmd.emit_last};
        end
        if (i_cmd.load_lidar) begin
            r_lts  <= r_l_rd.ts;
            r_pend <= '{kind: KIND_LIDAR, source_camera: '0, out_tag: r_l_rd.tag,
                        out_timestamp: r_l_rd.ts, last: 1'b0};
        end else if (i_cmd.load_cam) begin
            r_pend <= '{kind: KIND_CAMERA, source_camera: i_cmd.cam, out_tag: r_c_rd.tag,
                        out_timestamp: r_c_rd.ts, last: 1'b0};
        end
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hw/rtl/lcts_ctrl.sv =====
// ============================================================================
// lcts_ctrl
// Sequencer for the synchronization tick: lidar check, camera walk, finish.
// ============================================================================
module lcts_ctrl
    import lcts_pkg::*;
#(
    parameter int NUM_CAMERAS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [ACTION_W-1:0] i_action,
    input  t_dp_status          i_status,
    output logic                o_busy,
    output t_dp_cmd             o_cmd
);

    localparam int CAM_W = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;

    t_state           r_state;
    t_state           n_state;
    logic [CAM_W-1:0] r_cam;
    logic [CAM_W-1:0] n_cam;
    logic             cam_is_last;

    assign cam_is_last = (r_cam == CAM_W'(NUM_CAMERAS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cam   <= '0;
        end else begin
            r_state <= n_state;
            r_cam   <= n_cam;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cam   = r_cam;
        o_cmd   = '0;
        o_cmd.cam = CAM_FIELD_W'(r_cam);
        o_busy  = (r_state != ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_start;
                if (i_start && (i_action == ACT_TICK)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_cam = '0;
                if (i_status.lidar_empty) begin
                    n_state = ST_IDLE;
                end else if (i_status.any_cam_empty) begin
                    o_cmd.pop_lidar = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.load_lidar = 1'b1;
                    n_state          = ST_CAM_RD;
                end
            end
            ST_CAM_RD: begin
                if (!i_status.cam_empty) begin
                    n_state = ST_CAM_CMP;
                end else if (cam_is_last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_cam = r_cam + 1'b1;
                end
            end
            ST_CAM_CMP: begin
                o_cmd.cam_pop = 1'b1;
                if (i_status.cam_match) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.load_cam = 1'b1;
                    if (cam_is_last) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_cam   = r_cam + 1'b1;
                        n_state = ST_CAM_RD;
                    end
                end else begin
                    n_state = ST_CAM_RD;
                end
            end
            ST_FINISH: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = 1'b1;
                o_cmd.pop_lidar = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lidar_camera_timestamp_sync.sv =====
// ============================================================================
// lidar_camera_timestamp_sync
// Pairs the oldest lidar frame with at most one matching frame from each camera.
// ============================================================================
// An arrival transaction is taken and busy never rises for it. A tick that finds the
// lidar FIFO or any camera FIFO empty returns to idle from the check state; otherwise
// busy stays high while the cameras are walked in order, each camera entry examined
// passing through a read state and a compare state as the camera FIFO read is registered.
// Results follow on o_strobe, the last one in the first cycle with busy low; the
// receiver cannot stall. Reset (synchronous, active low) empties all FIFOs and sets
// tolerance to 50 ms.
module lidar_camera_timestamp_sync
    import lcts_pkg::*;
#(
    parameter int NUM_CAMERAS = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // Command side: a transaction is taken when start is high and busy is low.
    input  logic            start,
    output logic            busy,
    input  t_in_item        i_item,
    // Tolerance register write port.
    input  logic            i_cfg_we,
    input  logic [TS_W-1:0] i_cfg_wdata,
    // Result side: one result transaction per cycle with o_strobe high.
    output logic            o_strobe,
    output t_out_item       o_result
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // The controller owns sequencing: it accepts transactions, checks the lidar
    // and camera fill levels on a tick and then walks the cameras in order.
    lcts_ctrl #(
        .NUM_CAMERAS (NUM_CAMERAS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    // The datapath holds the FIFOs and the match compare. Each result is held in
    // a pending register until the next one is found or the walk ends, so that
    // the last flag is known when the result goes out.
    lcts_datapath #(
        .NUM_CAMERAS (NUM_CAMERAS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule
